/* hdl/spq_pkg.sv */
// Shared types, codes and helpers for the stable priority queue.
package spq_pkg;

    // Field widths fixed by the transaction format.
    localparam int PRIO_W = 3;
    localparam int ID_W   = 32;
    localparam int OCC_W  = 5;

    // Default sizing of the queue.
    localparam int CAPACITY_DEFAULT        = 16;
    localparam int PRIORITY_LEVELS_DEFAULT = 5;

    // Operation codes carried in the kind field.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // One held entry.
    typedef struct packed {
        logic [PRIO_W-1:0]      prio;
        logic signed [ID_W-1:0] id;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t new_entry;
    } cell_cmd_t;

    // Clamp a requested priority to the highest legal level.
    function automatic logic [PRIO_W-1:0] sat_priority(input logic [PRIO_W-1:0] prio,
                                                       input int levels);
        logic [PRIO_W-1:0] result;
        result = prio;
        if (int'(prio) >= levels)
        begin
            result = PRIO_W'(levels - 1);
        end
        return result;
    endfunction

endpackage

/* hdl/spq_if.sv */
// Valid/ready channel interfaces for requests and responses.
interface spq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [spq_pkg::PRIO_W-1:0]        priority_req;
    logic signed [spq_pkg::ID_W-1:0]   id_number;

    modport source (output valid, output kind, output priority_req, output id_number,
                    input ready);
    modport sink   (input valid, input kind, input priority_req, input id_number,
                    output ready);
endinterface

interface spq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [spq_pkg::PRIO_W-1:0]        out_priority;
    logic signed [spq_pkg::ID_W-1:0]   out_id;
    logic [spq_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output out_priority, output out_id,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_priority, input out_id,
                    input occupancy, output ready);
endinterface

/* hdl/spq_cell.sv */
// One slot of the sorted shift chain.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_behind,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               behind
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // A new entry goes behind this slot when the slot is held and the new entry is not more urgent.
    assign behind = occupied && (entry_reg.prio <= cmd.new_entry.prio);
    assign entry  = entry_reg;

    // Insert: slots behind the new entry shift one place toward the tail.
    // Remove: every slot takes its right neighbor.
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.insert)
        begin
            if (!behind)
            begin
                entry_next = left_behind ? cmd.new_entry : left_entry;
            end
        end
        else if (cmd.remove)
        begin
            entry_next = right_entry;
        end
    end

    // Slot storage carries payload only.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* hdl/stable_priority_queue.sv */
// Top level of the stable priority queue: cell chain, fill counter and result register.
// Stable priority queue. Entries are held in a chain of CAPACITY cells kept
// sorted by priority, lowest value at the head, with equal priorities in
// arrival order. Every request transaction (insert or remove) yields exactly
// one response transaction, registered in the cycle after the request is taken.
// The queue accepts one request per cycle: all cells update in parallel,
// each deciding from its own entry, its left neighbor's entry and flag, its
// right neighbor's entry and the broadcast request, and the response register
// frees the request side whenever it is empty or being drained. An insert into
// a full queue is dropped with status FULL; a remove from an empty queue
// returns status EMPTY with zero payload. No clearing pass is needed after reset.
module stable_priority_queue #(
    parameter int CAPACITY        = spq_pkg::CAPACITY_DEFAULT,
    parameter int PRIORITY_LEVELS = spq_pkg::PRIORITY_LEVELS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    spq_pkg::status_t            status_reg;
    spq_pkg::status_t            status_next;
    spq_pkg::entry_t             out_entry_reg;
    spq_pkg::entry_t             out_entry_next;

    logic                        accept;
    logic                        is_full;
    logic                        queue_empty;
    spq_pkg::cell_cmd_t          cmd;
    spq_pkg::entry_t             entry_w  [CAPACITY];
    logic                        behind_w [CAPACITY];

    // Handshake: take a request whenever the response register can be refilled.
    assign req.ready   = !rsp_valid_reg || rsp.ready;
    assign accept      = req.valid && req.ready;
    assign is_full     = (count_reg == CNT_W'(CAPACITY));
    assign queue_empty = (count_reg == '0);

    // Broadcast command for the cells.
    always_comb
    begin
        cmd.insert         = accept && (req.kind == spq_pkg::KIND_INSERT) && !is_full;
        cmd.remove         = accept && (req.kind == spq_pkg::KIND_REMOVE) && !queue_empty;
        cmd.new_entry.prio = spq_pkg::sat_priority(req.priority_req, PRIORITY_LEVELS);
        cmd.new_entry.id   = req.id_number;
    end

    // Chain of cells, slot 0 at the head.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_pkg::entry_t left_entry;
        logic            left_behind;
        spq_pkg::entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_entry  = cmd.new_entry;
            assign left_behind = 1'b1;
        end
        else
        begin : g_body
            assign left_entry  = entry_w[i-1];
            assign left_behind = behind_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = entry_w[i];
        end
        else
        begin : g_inner
            assign right_entry = entry_w[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (count_reg > CNT_W'(i)),
            .left_entry  (left_entry),
            .left_behind (left_behind),
            .right_entry (right_entry),
            .entry       (entry_w[i]),
            .behind      (behind_w[i])
        );
    end

    // Fill count and response contents.
    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        out_entry_next = out_entry_reg;
        if (rsp.valid && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            out_entry_next = '0;
            if (req.kind == spq_pkg::KIND_INSERT)
            begin
                if (is_full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = spq_pkg::ST_DONE;
                    count_next  = count_reg + 1'b1;
                end
            end
            else
            begin
                if (queue_empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next    = spq_pkg::ST_DONE;
                    out_entry_next = entry_w[0];
                    count_next     = count_reg - 1'b1;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload, occupancy taken from the count after the step.
    logic [CNT_W-1:0] occ_reg;

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        out_entry_reg <= out_entry_next;
        if (accept)
        begin
            occ_reg <= count_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_priority = out_entry_reg.prio;
    assign rsp.out_id       = out_entry_reg.id;
    assign rsp.occupancy    = spq_pkg::OCC_W'(occ_reg);

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    // A successful remove shrinks the count by one.
    a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == spq_pkg::KIND_REMOVE && !queue_empty)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not decrement the fill count");

    // A dropped insert leaves the count at capacity and reports FULL.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == spq_pkg::KIND_INSERT && is_full)
        |=> (status_reg == spq_pkg::ST_FULL && count_reg == CNT_W'(CAPACITY)))
        else $error("insert into full queue not dropped");

    // Every accepted request leaves a response pending.
    a_rsp_pending: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request produced no response");

endmodule
